// File: hdl/stereo_feedback_echo_defines.svh
// Assertion helpers used by the checker file of this block.
`ifndef STEREO_FEEDBACK_ECHO_DEFINES_SVH
`define STEREO_FEEDBACK_ECHO_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define SFE_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, switched off while reset is high.
`define SFE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// File: hdl/sfe_pkg.sv
package sfe_pkg;

   localparam int WORD_W      = 32;
   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 17;
   localparam int LEN_W       = 16;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 3;

   localparam logic [GAIN_W-1:0] MIX_DRY_RESET = 17'h10000;
   localparam logic [LEN_W-1:0]  DELAY_LENGTH_RESET = 16'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIX_DRY      = 3'd0,
      CSR_MIX_WET      = 3'd1,
      CSR_FB_DRY_SAME  = 3'd2,
      CSR_FB_WET_SAME  = 3'd3,
      CSR_FB_DRY_CROSS = 3'd4,
      CSR_FB_WET_CROSS = 3'd5,
      CSR_DELAY_LENGTH = 3'd6,
      CSR_STEREO_MODE  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] mix_dry;
      logic [GAIN_W-1:0] mix_wet;
      logic [GAIN_W-1:0] fb_dry_same;
      logic [GAIN_W-1:0] fb_wet_same;
      logic [GAIN_W-1:0] fb_dry_cross;
      logic [GAIN_W-1:0] fb_wet_cross;
   } gain_type;

   // Products of one channel, each kept modulo 2^32.
   typedef struct packed {
      logic [WORD_W-1:0] mix_dry_term;
      logic [WORD_W-1:0] mix_wet_term;
      logic [WORD_W-1:0] same_dry_term;
      logic [WORD_W-1:0] same_wet_term;
      logic [WORD_W-1:0] cross_dry_term;
      logic [WORD_W-1:0] cross_wet_term;
   } lane_terms_type;

   typedef struct packed {
      logic [WORD_W-1:0]   left_out;
      logic [WORD_W-1:0]   right_out;
      logic [SAMPLE_W-1:0] left_fb;
      logic [SAMPLE_W-1:0] right_fb;
   } merge_type;

endpackage

// File: hdl/sfe_ring.sv
module sfe_ring #(
   parameter int DEPTH = 32768,
   parameter int AW    = 15
) (
   input  logic                          clock,
   input  logic                          clear_en,
   input  logic [AW-1:0]                 clear_addr,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [sfe_pkg::SAMPLE_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [sfe_pkg::SAMPLE_W-1:0]  rd_data_ff
);

   logic [sfe_pkg::SAMPLE_W-1:0] mem [DEPTH];

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (clear_en) begin
         mem[clear_addr] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// File: hdl/sfe_lane.sv
module sfe_lane (
   input  logic                                clock,
   input  logic                                enable,
   input  sfe_pkg::gain_type                   gains,
   input  logic signed [sfe_pkg::SAMPLE_W-1:0] sample,
   input  logic signed [sfe_pkg::SAMPLE_W-1:0] delayed,
   output sfe_pkg::lane_terms_type             terms_ff
);

   sfe_pkg::lane_terms_type   terms_in;
   logic signed [16:0]        sample_x;
   logic signed [16:0]        delayed_x;
   logic signed [16:0]        delayed_p1;

   // Unsigned 17-bit gain times a signed 17-bit value, low 32 bits kept.
   function automatic logic [31:0] gain_mul(input logic [16:0] g,
                                            input logic signed [16:0] v);
      logic signed [17:0] gs;
      logic signed [34:0] p;
      gs = signed'({1'b0, g});
      p  = gs * v;
      return p[31:0];
   endfunction

   always_comb begin
      sample_x   = signed'({sample[15], sample});
      delayed_x  = signed'({delayed[15], delayed});
      delayed_p1 = delayed_x + 17'sd1;
      terms_in.mix_dry_term   = gain_mul(gains.mix_dry, sample_x);
      terms_in.mix_wet_term   = gain_mul(gains.mix_wet, delayed_x);
      terms_in.same_dry_term  = gain_mul(gains.fb_dry_same, sample_x);
      terms_in.same_wet_term  = gain_mul(gains.fb_wet_same, delayed_p1);
      terms_in.cross_dry_term = gain_mul(gains.fb_dry_cross, sample_x);
      terms_in.cross_wet_term = gain_mul(gains.fb_wet_cross, delayed_p1);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         terms_ff <= terms_in;
      end
   end

endmodule

// File: hdl/sfe_merge.sv
module sfe_merge (
   input  sfe_pkg::lane_terms_type left_terms,
   input  sfe_pkg::lane_terms_type right_terms,
   input  logic                    stereo,
   output sfe_pkg::merge_type      merged
);

   logic [sfe_pkg::WORD_W-1:0] left_sum;
   logic [sfe_pkg::WORD_W-1:0] right_sum;
   logic [sfe_pkg::WORD_W-1:0] left_cross;

   always_comb begin
      // In mono the left ring sees no contribution from the right channel.
      left_cross = stereo ? (right_terms.cross_wet_term + right_terms.cross_dry_term) : '0;
      left_sum   = left_terms.same_wet_term + left_terms.same_dry_term + left_cross;
      right_sum  = right_terms.same_wet_term + right_terms.same_dry_term
                 + left_terms.cross_wet_term + left_terms.cross_dry_term;
      merged.left_out  = left_terms.mix_dry_term + left_terms.mix_wet_term;
      merged.right_out = stereo ? (right_terms.mix_dry_term + right_terms.mix_wet_term) : '0;
      merged.left_fb   = left_sum[31:16];
      merged.right_fb  = right_sum[31:16];
   end

endmodule

// File: hdl/stereo_feedback_echo.sv
// Stereo feedback echo. Each item is one frame of two 16.16 words; the upper
// half of each word is the sample, mixed with the sample read from that
// channel's delay ring, and a weighted feedback value is written back to the
// same ring position. A taken item passes through the s1, s2 and output registers.
// The block takes one item per cycle while the ring length is three or more
// and the output is not stalled; a new item waits while an earlier item at
// the same ring position has not yet written back, so lengths of one and two
// take items less often. Ring throughput is set by the one read and one write
// port of each ring memory. After reset the rings are zeroed one entry per
// cycle; no item is taken during that pass, but configuration writes are.
// Configure only while idle.
module stereo_feedback_echo #(
   parameter int MAX_DELAY = 32768
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sfe_pkg::WORD_W-1:0]      req_left_in,
   input  logic signed [sfe_pkg::WORD_W-1:0]      req_right_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [sfe_pkg::WORD_W-1:0]      rsp_left_out,
   output logic signed [sfe_pkg::WORD_W-1:0]      rsp_right_out,
   input  logic                                   csr_wr_en,
   input  logic [sfe_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [sfe_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int AW = $clog2(MAX_DELAY);
   localparam int LW = $clog2(MAX_DELAY + 1);
   localparam int CW = (LW > sfe_pkg::LEN_W) ? LW : sfe_pkg::LEN_W;

   // Configuration
   sfe_pkg::gain_type             gains_ff;
   logic [sfe_pkg::LEN_W-1:0]     delay_length_ff;
   logic                          stereo_ff;

   // Ring clearing after reset
   logic                          clear_ff;
   logic                          clear_in;
   logic [AW-1:0]                 clear_addr_ff;
   logic [AW-1:0]                 clear_addr_in;

   // Ring position
   logic [AW-1:0]                 pos_ff;
   logic [AW-1:0]                 pos_in;
   logic [AW-1:0]                 pos_cur;
   logic [LW-1:0]                 pos_next_wide;
   logic [CW-1:0]                 len_wide;
   logic [LW-1:0]                 ring_len;

   // Pipeline control
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s2_valid_ff, s2_valid_in;
   logic                          out_valid_ff, out_valid_in;
   logic                          s1_move, s2_move, s1_free, out_free;
   logic                          hazard, accept;

   // Pipeline payload
   logic signed [sfe_pkg::SAMPLE_W-1:0] s1_left_ff, s1_right_ff;
   logic [AW-1:0]                       s1_pos_ff;
   logic [AW-1:0]                       s2_pos_ff;
   logic [sfe_pkg::WORD_W-1:0]          out_left_ff, out_right_ff;

   logic [sfe_pkg::SAMPLE_W-1:0]  rd_left, rd_right;
   sfe_pkg::lane_terms_type       left_terms, right_terms;
   sfe_pkg::merge_type            merged;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.mix_dry      <= sfe_pkg::MIX_DRY_RESET;
         gains_ff.mix_wet      <= '0;
         gains_ff.fb_dry_same  <= '0;
         gains_ff.fb_wet_same  <= '0;
         gains_ff.fb_dry_cross <= '0;
         gains_ff.fb_wet_cross <= '0;
         delay_length_ff       <= sfe_pkg::DELAY_LENGTH_RESET;
         stereo_ff             <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (sfe_pkg::csr_index_type'(csr_index))
            sfe_pkg::CSR_MIX_DRY:      gains_ff.mix_dry      <= csr_wdata;
            sfe_pkg::CSR_MIX_WET:      gains_ff.mix_wet      <= csr_wdata;
            sfe_pkg::CSR_FB_DRY_SAME:  gains_ff.fb_dry_same  <= csr_wdata;
            sfe_pkg::CSR_FB_WET_SAME:  gains_ff.fb_wet_same  <= csr_wdata;
            sfe_pkg::CSR_FB_DRY_CROSS: gains_ff.fb_dry_cross <= csr_wdata;
            sfe_pkg::CSR_FB_WET_CROSS: gains_ff.fb_wet_cross <= csr_wdata;
            sfe_pkg::CSR_DELAY_LENGTH: delay_length_ff <= csr_wdata[sfe_pkg::LEN_W-1:0];
            sfe_pkg::CSR_STEREO_MODE:  stereo_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // A length of zero acts as one; lengths beyond the ring size saturate.
   always_comb begin
      if (delay_length_ff == '0) begin
         len_wide = CW'(1);
      end else if (CW'(delay_length_ff) > CW'(MAX_DELAY)) begin
         len_wide = CW'(MAX_DELAY);
      end else begin
         len_wide = CW'(delay_length_ff);
      end
      ring_len = len_wide[LW-1:0];
      pos_cur  = (LW'(pos_ff) >= ring_len) ? '0 : pos_ff;
      pos_next_wide = LW'(pos_cur) + LW'(1);
      pos_in   = (pos_next_wide >= ring_len) ? '0 : pos_next_wide[AW-1:0];
   end

   always_comb begin
      out_free    = !out_valid_ff || !rsp_stall;
      s2_move     = s2_valid_ff && out_free;
      s1_move     = s1_valid_ff && (!s2_valid_ff || s2_move);
      s1_free     = !s1_valid_ff || s1_move;
      hazard      = (s1_valid_ff && (s1_pos_ff == pos_cur))
                 || (s2_valid_ff && (s2_pos_ff == pos_cur));
      req_stall   = clear_ff || !s1_free || hazard;
      accept      = req_valid && !req_stall;
      s1_valid_in  = accept || (s1_valid_ff && !s1_move);
      s2_valid_in  = s1_move || (s2_valid_ff && !s2_move);
      out_valid_in = s2_move || (out_valid_ff && rsp_stall);
      clear_in      = clear_ff && (clear_addr_ff != AW'(MAX_DELAY - 1));
      clear_addr_in = clear_addr_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         pos_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         if (clear_ff) begin
            clear_addr_ff <= clear_addr_in;
         end
         if (accept) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_left_ff  <= req_left_in[31:16];
         s1_right_ff <= req_right_in[31:16];
         s1_pos_ff   <= pos_cur;
      end
      if (s1_move) begin
         s2_pos_ff <= s1_pos_ff;
      end
      if (s2_move) begin
         out_left_ff  <= merged.left_out;
         out_right_ff <= merged.right_out;
      end
   end

   sfe_ring #(.DEPTH(MAX_DELAY), .AW(AW)) u_ring_left (
      .clock      (clock),
      .clear_en   (clear_ff),
      .clear_addr (clear_addr_ff),
      .wr_en      (s2_move),
      .wr_addr    (s2_pos_ff),
      .wr_data    (merged.left_fb),
      .rd_en      (accept),
      .rd_addr    (pos_cur),
      .rd_data_ff (rd_left)
   );

   // Feedback is not written to the right ring in mono; the clearing pass still zeroes it.
   sfe_ring #(.DEPTH(MAX_DELAY), .AW(AW)) u_ring_right (
      .clock      (clock),
      .clear_en   (clear_ff),
      .clear_addr (clear_addr_ff),
      .wr_en      (s2_move && stereo_ff),
      .wr_addr    (s2_pos_ff),
      .wr_data    (merged.right_fb),
      .rd_en      (accept),
      .rd_addr    (pos_cur),
      .rd_data_ff (rd_right)
   );

   sfe_lane u_lane_left (
      .clock    (clock),
      .enable   (s1_move),
      .gains    (gains_ff),
      .sample   (s1_left_ff),
      .delayed  (signed'(rd_left)),
      .terms_ff (left_terms)
   );

   sfe_lane u_lane_right (
      .clock    (clock),
      .enable   (s1_move),
      .gains    (gains_ff),
      .sample   (s1_right_ff),
      .delayed  (signed'(rd_right)),
      .terms_ff (right_terms)
   );

   sfe_merge u_merge (
      .left_terms  (left_terms),
      .right_terms (right_terms),
      .stereo      (stereo_ff),
      .merged      (merged)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_left_out  = signed'(out_left_ff);
   assign rsp_right_out = signed'(out_right_ff);

endmodule

// File: hdl/sfe_checker.sv
`include "stereo_feedback_echo_defines.svh"

module sfe_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall
);

   // The ring clearing pass holds off items right after reset.
   `SFE_ASSERT_IMPLIES(a_stall_after_reset, clock, reset, $past(reset), req_stall)

   // No result can be pending right after reset.
   `SFE_ASSERT_IMPLIES(a_no_rsp_after_reset, clock, reset, $past(reset), !rsp_valid)

   // A result that appears on an empty output was taken and passed through s1 and s2 without waiting.
   `SFE_ASSERT_IMPLIES(a_rsp_latency, clock, reset, $rose(rsp_valid),
                       $past(req_valid && !req_stall, 3))

   // A stalled result stays offered.
   `SFE_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind stereo_feedback_echo sfe_checker u_sfe_checker (.*);
